/* rtl/core/fdts_pkg.sv */
// ----------------------------------------------------------------------------
// fdts_pkg: shared types and constants for the work dispatcher
// Sizes of the wait queue and slot bank, command and status codes, and the
// request and result records passed between the pipeline stages.
// ----------------------------------------------------------------------------
package fdts_pkg;

  // Sizing
  localparam int NUM_SLOTS   = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_WIDTH    = 16;

  // Fixed field widths of the request and result
  localparam int CMD_W    = 2;
  localparam int ITEM_W   = 16;
  localparam int SIDX_W   = 4;
  localparam int STATUS_W = 3;
  localparam int SIU_W    = 4;

  // Derived widths
  localparam int SLOT_IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int LIM_W   = SIDX_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ARRIVE = 2'd0,
    CMD_CALL   = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_e_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_QEMPTY  = 3'd1,
    ST_BUSY    = 3'd2,
    ST_SEMPTY  = 3'd3,
    ST_BADSLOT = 3'd4,
    ST_QFULL   = 3'd5
  } status_e_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ITEM_W-1:0] item_id;
    logic [SIDX_W-1:0] slot_index;
  } fdts_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ITEM_W-1:0]   released_id;
    logic                released_valid;
  } fdts_res_t;

endpackage

/* rtl/core/fifo_dispatch_to_slots.sv */
// ----------------------------------------------------------------------------
// fifo_dispatch_to_slots: FIFO work dispatcher top level
// Path: an accepted request is captured in the input register, then the engine
//   loads its result into the result register, which drives out_*.
// Throughput: one request per cycle while out_tready is high (single-pass engine).
// Reset (rst_n low, synchronous): queue empties, all slots free, slots_in_use
//   returns to 0, both pipeline registers drop their valid.
// ----------------------------------------------------------------------------
module fifo_dispatch_to_slots
  import fdts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: slots_in_use
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  // Request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] item_id, [19:16] slot_index, [23:20] zero
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] status, [18:3] released_id, [23:19] zero
  output logic        out_tuser   // [0] released_valid
);

  fdts_req_t up_req;
  fdts_req_t req;
  fdts_res_t res;
  fdts_res_t out_res;
  logic      req_valid;
  logic      can_load;
  logic      fire;

  // Unpack the request
  assign up_req.cmd        = in_tuser;
  assign up_req.item_id    = in_tdata[15:0];
  assign up_req.slot_index = in_tdata[19:16];

  // Hold the incoming request until the engine can commit it
  fdts_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_tvalid),
    .up_ready  (in_tready),
    .up_req    (up_req),
    .req_valid (req_valid),
    .req_take  (can_load),
    .req       (req)
  );

  // Commit the request when the result register is free or draining
  assign fire = req_valid && can_load;

  fdts_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .req         (req),
    .res         (res)
  );

  fdts_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (fire),
    .res_in   (res),
    .can_load (can_load),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_res   (out_res)
  );

  // Pack the result
  assign out_tdata[2:0]   = out_res.status;
  assign out_tdata[18:3]  = out_res.released_id;
  assign out_tdata[23:19] = '0;
  assign out_tuser        = out_res.released_valid;

endmodule

/* rtl/core/fdts_in_stage.sv */
// ----------------------------------------------------------------------------
// fdts_in_stage: input request register
// Captures one request per cycle while the engine takes them; holds each until taken.
// ----------------------------------------------------------------------------
module fdts_in_stage
  import fdts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  fdts_req_t up_req,
  output logic      req_valid,
  input  logic      req_take,
  output fdts_req_t req
);

  logic      valid_r;
  logic      valid_nxt;
  fdts_req_t req_r;
  logic      load;

  assign up_ready  = !valid_r || req_take;
  assign load      = up_valid && up_ready;
  assign valid_nxt = load ? 1'b1 : (req_take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      req_r <= up_req;
    end
  end

  assign req_valid = valid_r;
  assign req       = req_r;

endmodule

/* rtl/core/fdts_engine.sv */
// ----------------------------------------------------------------------------
// fdts_engine: wait queue, slot bank and command decode
// Evaluates one request against the current state and commits the update
// in the same cycle the result is loaded downstream.
// ----------------------------------------------------------------------------
module fdts_engine
  import fdts_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [SIU_W-1:0] cfg_wr_data,
  input  logic             fire,
  input  fdts_req_t        req,
  output fdts_res_t        res
);

  logic [SIU_W-1:0]    slots_in_use_r;
  logic [ID_WIDTH-1:0] wait_store [QUEUE_DEPTH];
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [PTR_W-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ID_WIDTH-1:0] slot_holder [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] busy_r, busy_nxt;

  logic [SLOT_IW-1:0]  sidx;
  logic                slot_ok;
  logic                slot_busy;
  logic                q_empty;
  logic                q_full;
  logic                do_push;
  logic                do_call;
  logic                do_finish;
  logic [ID_WIDTH-1:0] item_trim;
  cmd_e_t              cmd;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign cmd       = cmd_e_t'(req.cmd);
  assign sidx      = SLOT_IW'(req.slot_index);
  assign slot_ok   = (LIM_W'(req.slot_index) < LIM_W'(slots_in_use_r)) &&
                     (LIM_W'(req.slot_index) < LIM_W'(NUM_SLOTS));
  assign slot_busy = busy_r[sidx];
  assign q_empty   = (count_r == '0);
  assign q_full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign item_trim = ID_WIDTH'(req.item_id);

  // Decode the command and its checks
  always_comb begin
    res.status         = ST_OK;
    res.released_id    = '0;
    res.released_valid = 1'b0;
    do_push            = 1'b0;
    do_call            = 1'b0;
    do_finish          = 1'b0;
    case (cmd)
      CMD_ARRIVE: begin
        if (q_full) begin
          res.status = ST_QFULL;
        end else begin
          do_push = 1'b1;
        end
      end
      CMD_CALL: begin
        if (!slot_ok) begin
          res.status = ST_BADSLOT;
        end else if (slot_busy) begin
          res.status = ST_BUSY;
        end else if (q_empty) begin
          res.status = ST_QEMPTY;
        end else begin
          do_call = 1'b1;
        end
      end
      CMD_FINISH: begin
        if (!slot_ok) begin
          res.status = ST_BADSLOT;
        end else if (!slot_busy) begin
          res.status = ST_SEMPTY;
        end else begin
          do_finish          = 1'b1;
          res.released_id    = ITEM_W'(slot_holder[sidx]);
          res.released_valid = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    busy_nxt  = busy_r;
    if (fire && do_push) begin
      tail_nxt  = next_ptr(tail_r);
      count_nxt = count_r + 1'b1;
    end
    if (fire && do_call) begin
      head_nxt       = next_ptr(head_r);
      count_nxt      = count_r - 1'b1;
      busy_nxt[sidx] = 1'b1;
    end
    if (fire && do_finish) begin
      busy_nxt[sidx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_in_use_r <= '0;
      head_r         <= '0;
      tail_r         <= '0;
      count_r        <= '0;
      busy_r         <= '0;
    end else begin
      if (cfg_wr_en) begin
        slots_in_use_r <= cfg_wr_data;
      end
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      busy_r  <= busy_nxt;
    end
  end

  // Storage arrays, no reset
  always_ff @(posedge clk) begin
    if (fire && do_push) begin
      wait_store[tail_r] <= item_trim;
    end
    if (fire && do_call) begin
      slot_holder[sidx] <= wait_store[head_r];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("wait count above queue depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == tail_r))
    else $error("empty queue with head and tail apart");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.status == ST_QFULL) |-> q_full)
    else $error("queue full reported below depth");

  a_call_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && do_call) |=> (count_r == $past(count_r) - 1'b1) && busy_r[$past(sidx)])
    else $error("call did not pop the queue into the slot");

  a_finish_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.released_valid) |=> !busy_r[$past(sidx)])
    else $error("finished slot still busy");

endmodule

/* rtl/core/fdts_out_stage.sv */
// ----------------------------------------------------------------------------
// fdts_out_stage: result register
// Holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module fdts_out_stage
  import fdts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  fdts_res_t res_in,
  output logic      can_load,
  output logic      dn_valid,
  input  logic      dn_ready,
  output fdts_res_t dn_res
);

  logic      valid_r;
  logic      valid_nxt;
  fdts_res_t res_r;

  assign can_load  = !valid_r || dn_ready;
  assign valid_nxt = load ? 1'b1 : (dn_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign dn_valid = valid_r;
  assign dn_res   = res_r;

endmodule
